[rtl/mvwf_pkg.sv]
`timescale 1ns / 1ps

package mvwf_pkg;

	localparam int PIX_W     = 8;
	localparam int NUM_ROWS  = 5;
	localparam int NUM_COLS  = 5;
	localparam int NUM_POS   = NUM_ROWS * NUM_COLS;
	localparam int NUM_STORE = NUM_COLS - 1;
	localparam int NUM_EXT   = NUM_COLS + 2;
	localparam int NUM_JOBS  = 3;
	localparam int NUM_WIN   = 9;
	localparam int WIN_PIX   = 9;
	localparam int KUW_FIRST = 5;
	localparam int MAX_WIDTH = 4096;

	localparam int COL_W   = 12;
	localparam int POS_W   = 5;
	localparam int SUM_W   = 12;
	localparam int SQP_W   = 2 * PIX_W;
	localparam int SQ_W    = 20;
	localparam int SCAT_W  = 23;
	localparam int MEAN_W  = 12;
	localparam int WIDX_W  = 4;

	// floor(16*sum/9) as sum * ceil(2^20/9) >> 16
	localparam int RECIP_SHIFT = 16;
	localparam int RECIP_W     = 17;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** (RECIP_SHIFT + 4) + 8) / 9);
	localparam int PROD_W      = SUM_W + RECIP_W;

	localparam logic [COL_W-1:0] LAST_COL = COL_W'(MAX_WIDTH - 1);

	typedef logic [PIX_W-1:0]          pix_t;
	typedef pix_t [NUM_ROWS-1:0]       column_t;
	typedef pix_t [NUM_POS-1:0]        grid_t;
	typedef logic [COL_W-1:0]          colidx_t;
	typedef logic [SUM_W-1:0]          sum_t;
	typedef logic [SQ_W-1:0]           sq_t;
	typedef logic [SCAT_W-1:0]         scat_t;
	typedef logic [MEAN_W-1:0]         mean_t;
	typedef logic [POS_W-1:0]          pos_t;

	typedef enum logic {
		MODE_KUWAHARA = 1'b0,
		MODE_NAGAO    = 1'b1
	} mode_t;

	typedef enum logic [1:0] {
		JOB_LEFT   = 2'd0,
		JOB_CENTRE = 2'd1,
		JOB_RIGHT  = 2'd2
	} job_t;

	typedef struct packed {
		logic    valid;
		colidx_t column;
		logic    last;
	} job_ctl_t;

	// window pixel positions, coded as x*5 + y
	localparam pos_t WIN_POS [NUM_WIN][WIN_PIX] = '{
		'{ 0,  1,  2,  3,  4,  6,  7,  8, 12},
		'{ 0,  5, 10, 15, 20,  6, 11, 16, 12},
		'{20, 21, 22, 23, 24, 16, 17, 18, 12},
		'{ 4,  9, 14, 19, 24,  8, 13, 18, 12},
		'{ 6,  7,  8, 11, 12, 13, 16, 17, 18},
		'{ 0,  1,  2,  5,  6,  7, 10, 11, 12},
		'{10, 11, 12, 15, 16, 17, 20, 21, 22},
		'{12, 13, 14, 17, 18, 19, 22, 23, 24},
		'{ 2,  3,  4,  7,  8,  9, 12, 13, 14}
	};

endpackage

[rtl/min_variance_window_filter_5x5.sv]
`timescale 1ns / 1ps

// Minimum-variance 5x5 window filter (Kuwahara / Nagao-Matsuyama).
// Input channel: one image column of five pixels per request, top and bottom
// edges already replicated, row_end on the last column of each row. Left and
// right edges are replicated inside. Output channel: one filtered centre pixel
// per request, the chosen window's mean in Q8.4, its index, its column and a
// flag on the last result that an input request causes.
// Configuration channel: filter_mode (0 four Kuwahara quadrants, 1 nine Nagao
// windows); cfg_ready is always high, write only while the block is idle.
// The first result of an input passes the issue register, stages s2 to s4 and the output register.
// Throughput: one result per cycle while the receiver is ready; one input per cycle,
// except that a row-end column yields up to three results and holds the issue stage
// until the last is issued, since the stats pipeline takes one centre per cycle.
// When the receiver stalls the whole result pipeline holds; one further input
// is still taken into the issue register. An input that yields no result
// (first columns of a row) is absorbed without occupying the pipeline.
// Reset clears the column store, the column count, the mode (Kuwahara) and
// all pipeline valid flags.

module min_variance_window_filter_5x5 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  pix_up2,
	input  logic [7:0]  pix_up1,
	input  logic [7:0]  pix_mid,
	input  logic [7:0]  pix_dn1,
	input  logic [7:0]  pix_dn2,
	input  logic        row_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [11:0] mean_q4,
	output logic [3:0]  window_index,
	output logic [11:0] out_column,
	output logic        last_of_run
);

	mvwf_pkg::mode_t   mode_q;
	mvwf_pkg::column_t [mvwf_pkg::NUM_STORE-1:0] store_q;
	mvwf_pkg::colidx_t count_q;

	mvwf_pkg::column_t in_col;
	mvwf_pkg::column_t [mvwf_pkg::NUM_STORE-1:0] eff_store;
	logic              in_acc;
	logic              col_first;
	logic              end_in;
	logic [mvwf_pkg::NUM_JOBS-1:0] pend_in;
	logic              load_s1;

	logic              v_s1;
	logic [mvwf_pkg::NUM_JOBS-1:0] pend_s1;
	mvwf_pkg::column_t [mvwf_pkg::NUM_STORE-1:0] store_s1;
	mvwf_pkg::column_t new_s1;
	mvwf_pkg::colidx_t base_s1;
	logic              end_s1;

	logic              advance;
	logic              issue;
	mvwf_pkg::job_t    job;
	logic [mvwf_pkg::NUM_JOBS-1:0] pend_rest;
	mvwf_pkg::column_t [mvwf_pkg::NUM_EXT-1:0] ext;
	mvwf_pkg::column_t [mvwf_pkg::NUM_COLS-1:0] job_cols;
	mvwf_pkg::job_ctl_t job_ctl;

	mvwf_pkg::job_ctl_t ctl_s2;
	mvwf_pkg::grid_t    grid_s2;
	mvwf_pkg::job_ctl_t ctl_s4;
	mvwf_pkg::scat_t [mvwf_pkg::NUM_WIN-1:0] scat_s4;
	mvwf_pkg::mean_t [mvwf_pkg::NUM_WIN-1:0] mean_s4;

	logic [mvwf_pkg::WIDX_W-1:0] best_idx;
	logic [mvwf_pkg::WIDX_W-1:0] sel_idx;
	mvwf_pkg::scat_t   best_scat;
	mvwf_pkg::mean_t   best_mean;
	logic              found;
	logic              in_set;

	logic              v_s5;
	mvwf_pkg::mean_t   mean_s5;
	logic [mvwf_pkg::WIDX_W-1:0] widx_s5;
	mvwf_pkg::colidx_t column_s5;
	logic              last_s5;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= mvwf_pkg::MODE_KUWAHARA;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= mvwf_pkg::mode_t'(cfg_data);
		end
	end

	// column store and edge handling
	assign in_col    = {pix_dn2, pix_dn1, pix_mid, pix_up1, pix_up2};
	assign in_acc    = in_valid && in_ready;
	assign col_first = (count_q == '0);
	assign end_in    = row_end || (count_q == mvwf_pkg::LAST_COL);
	assign pend_in   = {end_in, end_in && !col_first,
		count_q >= mvwf_pkg::COL_W'(2)};
	assign load_s1   = in_acc && (pend_in != '0);

	always_comb begin
		for (int k = 0; k < mvwf_pkg::NUM_STORE; k++) begin
			eff_store[k] = col_first ? in_col : store_q[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_q <= '0;
			count_q <= '0;
		end else if (in_acc) begin
			for (int k = 0; k < mvwf_pkg::NUM_STORE - 1; k++) begin
				store_q[k] <= eff_store[k + 1];
			end
			store_q[mvwf_pkg::NUM_STORE-1] <= in_col;
			count_q <= end_in ? '0 : count_q + mvwf_pkg::COL_W'(1);
		end
	end

	// issue stage: one centre per cycle from the held columns while the pipeline advances
	assign advance = !v_s5 || out_ready;
	assign issue   = v_s1 && advance;

	always_comb begin
		priority if (pend_s1[mvwf_pkg::JOB_LEFT]) begin
			job = mvwf_pkg::JOB_LEFT;
		end else if (pend_s1[mvwf_pkg::JOB_CENTRE]) begin
			job = mvwf_pkg::JOB_CENTRE;
		end else begin
			job = mvwf_pkg::JOB_RIGHT;
		end
	end

	always_comb begin
		pend_rest      = pend_s1;
		pend_rest[job] = 1'b0;
	end

	assign in_ready = !v_s1 || (issue && (pend_rest == '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			pend_s1 <= '0;
		end else if (load_s1) begin
			v_s1    <= 1'b1;
			pend_s1 <= pend_in;
		end else if (issue) begin
			v_s1    <= (pend_rest != '0);
			pend_s1 <= pend_rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			store_s1 <= eff_store;
			new_s1   <= in_col;
			base_s1  <= count_q;
			end_s1   <= end_in;
		end
	end

	assign ext = {new_s1, new_s1, new_s1, store_s1};

	always_comb begin
		job_ctl.valid  = issue;
		job_ctl.column = base_s1 + mvwf_pkg::COL_W'(job) - mvwf_pkg::COL_W'(2);
		unique case (job)
			mvwf_pkg::JOB_LEFT: begin
				job_cols     = ext[4:0];
				job_ctl.last = !end_s1;
			end
			mvwf_pkg::JOB_CENTRE: begin
				job_cols     = ext[5:1];
				job_ctl.last = 1'b0;
			end
			default: begin
				job_cols     = ext[6:2];
				job_ctl.last = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (advance) begin
			ctl_s2 <= job_ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			grid_s2 <= mvwf_pkg::grid_t'(job_cols);
		end
	end

	mvwf_window_stats u_stats (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (advance),
		.ctl_s2  (ctl_s2),
		.grid_s2 (grid_s2),
		.ctl_s4  (ctl_s4),
		.scat_s4 (scat_s4),
		.mean_s4 (mean_s4)
	);

	// least spread, lowest index on a tie
	always_comb begin
		best_idx  = '0;
		best_scat = '0;
		best_mean = '0;
		found     = 1'b0;
		in_set    = 1'b0;
		for (int w = 0; w < mvwf_pkg::NUM_WIN; w++) begin
			in_set = (mode_q == mvwf_pkg::MODE_NAGAO) || (w >= mvwf_pkg::KUW_FIRST);
			if (in_set && (!found || (scat_s4[w] < best_scat))) begin
				found     = 1'b1;
				best_idx  = mvwf_pkg::WIDX_W'(w);
				best_scat = scat_s4[w];
				best_mean = mean_s4[w];
			end
		end
		sel_idx = (mode_q == mvwf_pkg::MODE_NAGAO) ? best_idx :
			best_idx - mvwf_pkg::WIDX_W'(mvwf_pkg::KUW_FIRST);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (advance) begin
			v_s5 <= ctl_s4.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mean_s5   <= best_mean;
			widx_s5   <= sel_idx;
			column_s5 <= ctl_s4.column;
			last_s5   <= ctl_s4.last;
		end
	end

	assign out_valid    = v_s5;
	assign mean_q4      = mean_s5;
	assign window_index = widx_s5;
	assign out_column   = column_s5;
	assign last_of_run  = last_s5;

`ifndef SYNTH
	a_pend_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (pend_s1 != '0))
		else $error("issue register valid with no centre pending");

	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> in_ready)
		else $error("input stalled with free issue register");

	a_row_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && row_end) |=> (count_q == '0))
		else $error("column count not restarted after row end");

	a_mean_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (mean_q4 <= mvwf_pkg::MEAN_W'(4080)))
		else $error("mean out of range");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(mean_q4) &&
			$stable(window_index) && $stable(out_column) && $stable(last_of_run)))
		else $error("result changed while stalled");
`endif

endmodule

[rtl/mvwf_window_stats.sv]
`timescale 1ns / 1ps

module mvwf_window_stats (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        en,
	input  mvwf_pkg::job_ctl_t                          ctl_s2,
	input  mvwf_pkg::grid_t                             grid_s2,
	output mvwf_pkg::job_ctl_t                          ctl_s4,
	output mvwf_pkg::scat_t [mvwf_pkg::NUM_WIN-1:0]     scat_s4,
	output mvwf_pkg::mean_t [mvwf_pkg::NUM_WIN-1:0]     mean_s4
);

	logic [mvwf_pkg::SQP_W-1:0] sqp [mvwf_pkg::NUM_POS];
	mvwf_pkg::sum_t [mvwf_pkg::NUM_WIN-1:0] sum_c;
	mvwf_pkg::sq_t  [mvwf_pkg::NUM_WIN-1:0] sq_c;

	mvwf_pkg::job_ctl_t ctl_s3;
	mvwf_pkg::sum_t [mvwf_pkg::NUM_WIN-1:0] sum_s3;
	mvwf_pkg::sq_t  [mvwf_pkg::NUM_WIN-1:0] sq_s3;

	mvwf_pkg::scat_t [mvwf_pkg::NUM_WIN-1:0] scat_c;
	mvwf_pkg::mean_t [mvwf_pkg::NUM_WIN-1:0] mean_c;

	// pixel squares and per-window sums
	always_comb begin
		for (int p = 0; p < mvwf_pkg::NUM_POS; p++) begin
			sqp[p] = {{mvwf_pkg::PIX_W{1'b0}}, grid_s2[p]} *
				{{mvwf_pkg::PIX_W{1'b0}}, grid_s2[p]};
		end
		for (int w = 0; w < mvwf_pkg::NUM_WIN; w++) begin
			sum_c[w] = '0;
			sq_c[w]  = '0;
			for (int i = 0; i < mvwf_pkg::WIN_PIX; i++) begin
				sum_c[w] = sum_c[w] + mvwf_pkg::SUM_W'(grid_s2[mvwf_pkg::WIN_POS[w][i]]);
				sq_c[w]  = sq_c[w] + mvwf_pkg::SQ_W'(sqp[mvwf_pkg::WIN_POS[w][i]]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3 <= sum_c;
			sq_s3  <= sq_c;
		end
	end

	// 9*sum(p^2) - sum(p)^2 and floor(16*sum/9)
	always_comb begin
		logic [2*mvwf_pkg::SUM_W-1:0] sum_sq;
		logic [mvwf_pkg::PROD_W-1:0]  prod;
		for (int w = 0; w < mvwf_pkg::NUM_WIN; w++) begin
			sum_sq    = {{mvwf_pkg::SUM_W{1'b0}}, sum_s3[w]} *
				{{mvwf_pkg::SUM_W{1'b0}}, sum_s3[w]};
			scat_c[w] = mvwf_pkg::SCAT_W'({sq_s3[w], 3'b000}) + mvwf_pkg::SCAT_W'(sq_s3[w])
				- mvwf_pkg::SCAT_W'(sum_sq);
			prod      = mvwf_pkg::PROD_W'(sum_s3[w]) * mvwf_pkg::PROD_W'(mvwf_pkg::RECIP);
			mean_c[w] = prod[mvwf_pkg::RECIP_SHIFT +: mvwf_pkg::MEAN_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
		end else if (en) begin
			ctl_s4 <= ctl_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			scat_s4 <= scat_c;
			mean_s4 <= mean_c;
		end
	end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;

	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int ROW_COLS      = 32;

	// 5x5 window membership, bit x*5+y
	localparam logic [8:0][24:0] WINDOW_MASK = {
		25'h000739C, 25'h1CE7000, 25'h0739C00, 25'h0001CE7, 25'h00739C0,
		25'h10C7310, 25'h1F71000, 25'h0119C61, 25'h00011DF
	};

	typedef struct packed {
		logic [11:0] mean;
		logic [3:0]  idx;
		logic [11:0] column;
		logic        last;
	} pixel_result_t;

	typedef enum {
		FILL_RANDOM, FILL_TWO_LEVEL, FILL_FLAT, FILL_GENTLE, FILL_VERT_STEP, FILL_HORIZ_STEP
	} fill_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_data = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  pix_up2 = '0;
	logic [7:0]  pix_up1 = '0;
	logic [7:0]  pix_mid = '0;
	logic [7:0]  pix_dn1 = '0;
	logic [7:0]  pix_dn2 = '0;
	logic        row_end = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [11:0] mean_q4;
	logic [3:0]  window_index;
	logic [11:0] out_column;
	logic        last_of_run;

	min_variance_window_filter_5x5 u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pix_up2      (pix_up2),
		.pix_up1      (pix_up1),
		.pix_mid      (pix_mid),
		.pix_dn1      (pix_dn1),
		.pix_dn2      (pix_dn2),
		.row_end      (row_end),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.mean_q4      (mean_q4),
		.window_index (window_index),
		.out_column   (out_column),
		.last_of_run  (last_of_run)
	);

	pixel_result_t             pending_pixels[$];
	mvwf_pkg::column_t [3:0]   col_hist = '0;
	logic [11:0]               next_col = '0;
	mvwf_pkg::mode_t           cur_mode = mvwf_pkg::MODE_KUWAHARA;
	int              in_idle_pct = 0;
	int              out_stall_pct = 0;
	int              columns_sent = 0;
	int              pixels_checked = 0;
	int              mode_writes = 0;
	int              mismatches = 0;
	int              cycle_count = 0;
	pixel_result_t   want;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99, 0) >= out_stall_pct);
	end

	function automatic pixel_result_t choose_window(mvwf_pkg::column_t [4:0] span,
			logic [11:0] column, bit last);
		pixel_result_t res;
		int unsigned first_w, n_w, s, sq, spread, best_spread, best_sum, best_w, p;
		first_w = (cur_mode == mvwf_pkg::MODE_NAGAO) ? 0 : 5;
		n_w = (cur_mode == mvwf_pkg::MODE_NAGAO) ? 9 : 4;
		best_spread = 0;
		best_sum = 0;
		best_w = 0;
		for (int w = 0; w < n_w; w++) begin
			s = 0;
			sq = 0;
			for (int pos = 0; pos < 25; pos++) begin
				if (WINDOW_MASK[first_w + w][pos]) begin
					p = span[pos / 5][pos % 5];
					s += p;
					sq += p * p;
				end
			end
			spread = 9 * sq - s * s;
			if (w == 0 || spread < best_spread) begin
				best_spread = spread;
				best_sum = s;
				best_w = w;
			end
		end
		res.mean = 12'((16 * best_sum) / 9);
		res.idx = 4'(best_w);
		res.column = column;
		res.last = last;
		return res;
	endfunction

	function automatic void predict_column(mvwf_pkg::column_t incoming, bit end_flag);
		mvwf_pkg::column_t [6:0] ext;
		logic [11:0] c;
		bit ends;
		c = next_col;
		ends = end_flag || (c == mvwf_pkg::LAST_COL);
		if (c == 0)
			col_hist = {4{incoming}};
		ext = {incoming, incoming, incoming, col_hist};
		if (c >= 2)
			pending_pixels.push_back(choose_window(ext[4:0], c - 12'd2, !ends));
		if (ends) begin
			if (c >= 1)
				pending_pixels.push_back(choose_window(ext[5:1], c - 12'd1, 1'b0));
			pending_pixels.push_back(choose_window(ext[6:2], c, 1'b1));
			next_col = '0;
		end else begin
			next_col = c + 12'd1;
		end
		col_hist = ext[4:1];
	endfunction

	function automatic mvwf_pkg::column_t make_column(fill_t fill, int base, int x);
		mvwf_pkg::column_t col;
		for (int r = 0; r < 5; r++) begin
			case (fill)
				FILL_FLAT:       col[r] = mvwf_pkg::pix_t'(base);
				FILL_GENTLE:     col[r] = mvwf_pkg::pix_t'(base + $urandom_range(3, 0));
				FILL_TWO_LEVEL:  col[r] = $urandom_range(1, 0) ? 8'hFF : 8'h00;
				FILL_VERT_STEP:  col[r] = (x < base) ? 8'h00 : 8'hFF;
				FILL_HORIZ_STEP: col[r] = (r < 2) ? 8'hFF : mvwf_pkg::pix_t'(base);
				default:         col[r] = mvwf_pkg::pix_t'($urandom_range(255, 0));
			endcase
		end
		return col;
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: mean %0d window %0d column %0d last %0b",
						mean_q4, window_index, out_column, last_of_run);
			end else begin
				want = pending_pixels.pop_front();
				pixels_checked++;
				if (mean_q4 !== want.mean || window_index !== want.idx ||
						out_column !== want.column || last_of_run !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: expected mean %0d window %0d column %0d last %0b,",
							" got mean %0d window %0d column %0d last %0b"},
							want.mean, want.idx, want.column, want.last,
							mean_q4, window_index, out_column, last_of_run);
				end
			end
		end
	end

	task automatic send_column(mvwf_pkg::column_t col, bit end_flag);
		while ($urandom_range(99, 0) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pix_up2 <= col[0];
		pix_up1 <= col[1];
		pix_mid <= col[2];
		pix_dn1 <= col[3];
		pix_dn2 <= col[4];
		row_end <= end_flag;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_column(col, end_flag);
		columns_sent++;
	endtask

	task automatic send_row(int width, fill_t fill, int base);
		for (int x = 0; x < width; x++)
			send_column(make_column(fill, base, x), x == width - 1);
	endtask

	task automatic wait_until_drained();
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(mvwf_pkg::mode_t m);
		wait_until_drained();
		cfg_valid <= 1'b1;
		cfg_data <= m;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cur_mode = m;
		mode_writes++;
		cfg_valid <= 1'b0;
	endtask

	task automatic send_random_row();
		int width;
		fill_t fill;
		width = ($urandom_range(9, 0) == 0) ? $urandom_range(60, 20) : $urandom_range(12, 1);
		case ($urandom_range(7, 0))
			0:       fill = FILL_TWO_LEVEL;
			1:       fill = FILL_FLAT;
			2, 3:    fill = FILL_GENTLE;
			4:       fill = FILL_VERT_STEP;
			5:       fill = FILL_HORIZ_STEP;
			default: fill = FILL_RANDOM;
		endcase
		send_row(width, fill, (fill == FILL_VERT_STEP) ? $urandom_range(width, 0)
			: $urandom_range(252, 0));
	endtask

	// reset mode is kuwahara, extremes of the pixel range
	task automatic test_reset_mode();
		in_idle_pct = 29;
		out_stall_pct = 29;
		send_row(1, FILL_FLAT, 255);
		send_row(1, FILL_FLAT, 0);
		send_row(2, FILL_TWO_LEVEL, 0);
	endtask

	task automatic test_short_rows();
		write_mode(mvwf_pkg::MODE_NAGAO);
		send_row(1, FILL_TWO_LEVEL, 0);
		send_row(2, FILL_RANDOM, 0);
		send_row(3, FILL_TWO_LEVEL, 0);
	endtask

	task automatic test_step_edges();
		write_mode(mvwf_pkg::MODE_KUWAHARA);
		send_row(4, FILL_VERT_STEP, 2);
		send_row(4, FILL_HORIZ_STEP, 0);
		write_mode(mvwf_pkg::MODE_NAGAO);
		send_row(4, FILL_VERT_STEP, 2);
		send_row(4, FILL_HORIZ_STEP, 0);
	endtask

	task automatic test_drain_pause();
		in_idle_pct = 0;
		out_stall_pct = 29;
		for (int x = 0; x < 10; x++) begin
			if (x == 5)
				wait_until_drained();
			send_column(make_column(FILL_RANDOM, 0, x), x == 9);
		end
	endtask

	task automatic test_random_streams();
		int target;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
				1: begin in_idle_pct = 65; out_stall_pct = 0;  end
				2: begin in_idle_pct = 0;  out_stall_pct = 65; end
				default: begin in_idle_pct = 29; out_stall_pct = 29; end
			endcase
			for (int half = 0; half < 2; half++) begin
				write_mode(((phase + half) % 2 == 1) ? mvwf_pkg::MODE_NAGAO
					: mvwf_pkg::MODE_KUWAHARA);
				target = columns_sent + ROW_COLS;
				while (columns_sent < target)
					send_random_row();
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_mode();
		test_short_rows();
		test_step_edges();
		test_drain_pause();
		test_random_streams();
		wait_until_drained();
		$display("covered %0d columns incl. short rows and step edges, %0d pixels checked",
			columns_sent, pixels_checked);
		$display("%0d mode writes, both window sets, four handshake idling phases",
			mode_writes);
		if (mismatches == 0 && pending_pixels.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[sim.f]
rtl/mvwf_pkg.sv
rtl/mvwf_window_stats.sv
rtl/min_variance_window_filter_5x5.sv
bench/testbench.sv
